/* rtl/core/scts_pkg.sv */
// ----------------------------------------------------------------------------
// scts_pkg
// Types and constants shared by the capture header stripper and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package scts_pkg;

  // Default datagram length limit, in bytes
  localparam int unsigned MAX_DGRAM_BYTES_DEF = 4096;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENCAP_TYPE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_PAD       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_END       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_SIGNAL    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_NOISE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TAG_FCS_ERROR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_ALL      = 3'd6;

  // Register reset values
  localparam logic [15:0] ENCAP_TYPE_RST    = 16'd0;
  localparam logic [7:0]  TAG_PAD_RST       = 8'd0;
  localparam logic [7:0]  TAG_END_RST       = 8'd1;
  localparam logic [7:0]  TAG_SIGNAL_RST    = 8'd2;
  localparam logic [7:0]  TAG_NOISE_RST     = 8'd3;
  localparam logic [7:0]  TAG_FCS_ERROR_RST = 8'd4;

  // Header byte positions of the link type
  localparam int unsigned LINK_LO_POS = 2;
  localparam int unsigned LINK_HI_POS = 3;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TAG     = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_SKIP    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DROP    = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    CAP_NONE   = 2'd0,
    CAP_SIGNAL = 2'd1,
    CAP_NOISE  = 2'd2
  } cap_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_last;
    logic [7:0] signal_level;
    logic [7:0] noise_level;
    logic       fcs_error;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/sensor_capture_header_tlv_strip_unit.sv */
// ----------------------------------------------------------------------------
// sensor_capture_header_tlv_strip_unit
// Strips the capture header and tag list from a datagram, passes the frame on.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries one datagram byte per
//   beat with a last-byte mark. Output channel (out_valid/out_stall/out_data)
//   carries one frame byte per beat with the signal, noise and FCS-error
//   values gathered from the tags of the same datagram.
//   Configuration writes go through cfg_valid/cfg_ready (always ready), one register
//   per beat; the user must make them while the block is idle, which it does not enforce.
//   A payload byte is registered and appears on the output in the cycle after
//   its input beat. Throughput: one byte per cycle while no stalled output beat
//   is held; the per-byte tag walker and the output register then both take a byte every cycle.
//   Header and tag bytes produce no output beat; dropped datagrams produce
//   none at all.
//   Reset clears the walker to the start of a datagram, loads the register
//   defaults and empties the output register.
//   When the receiver stalls a full output register, in_stall rises in the
//   same cycle and the held beat stays unchanged until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_capture_header_tlv_strip_unit #(
  parameter int unsigned MAX_DGRAM_BYTES = scts_pkg::MAX_DGRAM_BYTES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire scts_pkg::in_item_t                  in_data,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      scts_pkg::out_item_t                 out_data,
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [scts_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [scts_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import scts_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_DGRAM_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_DGRAM_BYTES - 1);
  localparam logic [POS_W-1:0] POS_LO   = POS_W'(LINK_LO_POS);
  localparam logic [POS_W-1:0] POS_HI   = POS_W'(LINK_HI_POS);

  // configuration registers
  logic [15:0] encap_type;
  logic [7:0]  tag_pad, tag_end, tag_signal, tag_noise, tag_fcs_error;
  logic        drop_all;

  // walker state
  phase_t           phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       skip_remaining, skip_remaining_next;
  cap_t             capture_target, capture_target_next;
  logic [7:0]       link_low_byte, link_low_byte_next;
  logic [7:0]       held_signal, held_signal_next;
  logic [7:0]       held_noise, held_noise_next;
  logic             held_error, held_error_next;

  logic        accept, last, cut, emit;
  logic [7:0]  b;
  logic [7:0]  cap_signal, cap_noise;
  logic        is_pad, is_end, is_signal, is_noise, is_fcs;
  out_item_t   result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      encap_type    <= ENCAP_TYPE_RST;
      tag_pad       <= TAG_PAD_RST;
      tag_end       <= TAG_END_RST;
      tag_signal    <= TAG_SIGNAL_RST;
      tag_noise     <= TAG_NOISE_RST;
      tag_fcs_error <= TAG_FCS_ERROR_RST;
      drop_all      <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ENCAP_TYPE:    encap_type    <= cfg_data;
        REG_TAG_PAD:       tag_pad       <= cfg_data[7:0];
        REG_TAG_END:       tag_end       <= cfg_data[7:0];
        REG_TAG_SIGNAL:    tag_signal    <= cfg_data[7:0];
        REG_TAG_NOISE:     tag_noise     <= cfg_data[7:0];
        REG_TAG_FCS_ERROR: tag_fcs_error <= cfg_data[7:0];
        REG_DROP_ALL:      drop_all      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign b        = in_data.in_byte;
  assign last     = in_data.last_byte;
  assign cut      = !last && (byte_position >= POS_LAST);

  // tag decode, pad first, then end, signal, noise, FCS error
  assign is_pad    = (b == tag_pad);
  assign is_end    = !is_pad && (b == tag_end);
  assign is_signal = !is_pad && !is_end && (b == tag_signal);
  assign is_noise  = !is_pad && !is_end && !is_signal && (b == tag_noise);
  assign is_fcs    = !is_pad && !is_end && !is_signal && !is_noise && (b == tag_fcs_error);

  // level byte lands on the beat after the length byte
  always_comb begin
    cap_signal = held_signal;
    cap_noise  = held_noise;
    if (phase != PH_LENGTH) begin
      if (capture_target == CAP_SIGNAL) cap_signal = b;
      if (capture_target == CAP_NOISE)  cap_noise  = b;
    end
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (accept) begin
      if (phase == PH_DROP) begin
        if (last) phase_next = PH_HEADER;
      end else if (drop_all) begin
        phase_next = last ? PH_HEADER : PH_DROP;
      end else begin
        unique case (phase)
          PH_HEADER: begin
            if (byte_position == POS_HI)
              phase_next = ({b, link_low_byte} == encap_type) ? PH_TAG : PH_DROP;
          end
          PH_TAG: begin
            if (is_end)       phase_next = PH_PAYLOAD;
            else if (!is_pad) phase_next = PH_LENGTH;
          end
          PH_LENGTH:  phase_next = (b != 8'd0) ? PH_SKIP : PH_TAG;
          PH_SKIP:    if (skip_remaining == 8'd1) phase_next = PH_TAG;
          PH_PAYLOAD: ;
          default:    phase_next = PH_DROP;
        endcase
        if (last)     phase_next = PH_HEADER;
        else if (cut) phase_next = PH_DROP;
      end
    end
  end

  // datapath next values and result
  always_comb begin
    byte_position_next  = byte_position;
    skip_remaining_next = skip_remaining;
    capture_target_next = capture_target;
    link_low_byte_next  = link_low_byte;
    held_signal_next    = held_signal;
    held_noise_next     = held_noise;
    held_error_next     = held_error;
    emit                = 1'b0;
    result.payload_byte = b;
    result.payload_last = last || cut;
    result.signal_level = cap_signal;
    result.noise_level  = cap_noise;
    result.fcs_error    = held_error;
    if (accept && (phase == PH_DROP || drop_all)) begin
      if (last) begin
        byte_position_next  = '0;
        skip_remaining_next = '0;
        capture_target_next = CAP_NONE;
        link_low_byte_next  = '0;
        held_signal_next    = '0;
        held_noise_next     = '0;
        held_error_next     = 1'b0;
      end
    end else if (accept) begin
      held_signal_next = cap_signal;
      held_noise_next  = cap_noise;
      if (phase != PH_LENGTH) capture_target_next = CAP_NONE;
      case (phase)
        PH_HEADER: if (byte_position == POS_LO) link_low_byte_next = b;
        PH_TAG: begin
          if (is_signal)   capture_target_next = CAP_SIGNAL;
          else if (is_noise) capture_target_next = CAP_NOISE;
          else if (is_fcs) held_error_next = 1'b1;
        end
        PH_LENGTH:  skip_remaining_next = b;
        PH_SKIP:    skip_remaining_next = skip_remaining - 8'd1;
        PH_PAYLOAD: emit = 1'b1;
        default: ;
      endcase
      if (last) begin
        byte_position_next  = '0;
        skip_remaining_next = '0;
        capture_target_next = CAP_NONE;
        link_low_byte_next  = '0;
        held_signal_next    = '0;
        held_noise_next     = '0;
        held_error_next     = 1'b0;
      end else if (!cut) begin
        byte_position_next = byte_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      byte_position  <= '0;
      skip_remaining <= '0;
      capture_target <= CAP_NONE;
      link_low_byte  <= '0;
      held_signal    <= '0;
      held_noise     <= '0;
      held_error     <= 1'b0;
    end else begin
      phase          <= phase_next;
      byte_position  <= byte_position_next;
      skip_remaining <= skip_remaining_next;
      capture_target <= capture_target_next;
      link_low_byte  <= link_low_byte_next;
      held_signal    <= held_signal_next;
      held_noise     <= held_noise_next;
      held_error     <= held_error_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/scts_checker.sv */
// ----------------------------------------------------------------------------
// scts_checker
// Port-level checks on the header stripper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scts_checker (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire scts_pkg::in_item_t  in_data,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire scts_pkg::out_item_t out_data
);

  import scts_pkg::*;

  // the input only backs up behind a held output beat
  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled output beat");

  // a stalled beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output beat changed");

  // no beat appears without an input beat behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    (!(in_valid && !in_stall) && !(out_valid && out_stall)) |=> !out_valid)
    else $error("output beat with no input beat");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind sensor_capture_header_tlv_strip_unit scts_checker u_scts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

/* verif/scts_frame_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scts_frame_checker
// Tracks the header walk on every accepted datagram byte, queues the frame
// beats the stripper should emit and compares each output beat against them.
// ----------------------------------------------------------------------------

module scts_frame_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  scts_pkg::in_item_t              in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  scts_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [scts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [scts_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);

  import scts_pkg::*;

  // register copies
  logic [15:0] exp_encap;
  logic [7:0]  code_pad, code_end, code_signal, code_noise, code_fcs;
  logic        paused;

  // walker state
  phase_t      walk_phase;
  int unsigned pos;
  logic [7:0]  skip_left;
  cap_t        grab;
  logic [7:0]  link_lo, lvl_signal, lvl_noise;
  logic        err_seen;

  out_item_t   frame_q[$];
  out_item_t   want, beat;

  function void restart_dgram();
    walk_phase = PH_HEADER;
    pos        = 0;
    skip_left  = '0;
    grab       = CAP_NONE;
    link_lo    = '0;
    lvl_signal = '0;
    lvl_noise  = '0;
    err_seen   = 1'b0;
  endfunction

  // Walks one datagram byte; returns 1 when a frame beat comes out of it
  function bit strip_byte(input in_item_t it, output out_item_t fb);
    logic [7:0] b;
    bit         last, cut, fin, emit;
    b    = it.in_byte;
    last = it.last_byte;
    emit = 1'b0;
    fb   = '0;
    if (walk_phase == PH_DROP) begin
      if (last) restart_dgram();
      return 1'b0;
    end
    cut = !last && (pos >= MAX_DGRAM_BYTES_DEF - 1);
    fin = last || cut;
    if (paused) begin
      if (last) restart_dgram();
      else walk_phase = PH_DROP;
      return 1'b0;
    end
    // level byte follows the length byte, even a zero one
    if (grab != CAP_NONE && walk_phase != PH_LENGTH) begin
      if (grab == CAP_SIGNAL) lvl_signal = b;
      else lvl_noise = b;
      grab = CAP_NONE;
    end
    case (walk_phase)
      PH_HEADER: begin
        if (pos == LINK_LO_POS) link_lo = b;
        else if (pos == LINK_HI_POS) walk_phase = ({b, link_lo} == exp_encap) ? PH_TAG : PH_DROP;
      end
      PH_TAG: begin
        if (b == code_pad) begin
          // single-byte filler
        end else if (b == code_end) begin
          walk_phase = PH_PAYLOAD;
        end else begin
          if (b == code_signal) grab = CAP_SIGNAL;
          else if (b == code_noise) grab = CAP_NOISE;
          else if (b == code_fcs) err_seen = 1'b1;
          walk_phase = PH_LENGTH;
        end
      end
      PH_LENGTH: begin
        skip_left  = b;
        walk_phase = (b != 8'd0) ? PH_SKIP : PH_TAG;
      end
      PH_SKIP: begin
        skip_left = skip_left - 8'd1;
        if (skip_left == 8'd0) walk_phase = PH_TAG;
      end
      PH_PAYLOAD: begin
        fb.payload_byte = b;
        fb.payload_last = fin;
        fb.signal_level = lvl_signal;
        fb.noise_level  = lvl_noise;
        fb.fcs_error    = err_seen;
        emit = 1'b1;
      end
      default: walk_phase = PH_DROP;
    endcase
    if (last) restart_dgram();
    else if (cut) walk_phase = PH_DROP;
    else pos++;
    return emit;
  endfunction

  function void check_field(input string field, input int unsigned exp_v, input int unsigned got);
    if (exp_v != got) begin
      $error("%s: expected %0h, got %0h", field, exp_v, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      exp_encap   = ENCAP_TYPE_RST;
      code_pad    = TAG_PAD_RST;
      code_end    = TAG_END_RST;
      code_signal = TAG_SIGNAL_RST;
      code_noise  = TAG_NOISE_RST;
      code_fcs    = TAG_FCS_ERROR_RST;
      paused      = 1'b0;
      restart_dgram();
      frame_q.delete();
      fail_count  = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENCAP_TYPE:    exp_encap   = cfg_data;
          REG_TAG_PAD:       code_pad    = cfg_data[7:0];
          REG_TAG_END:       code_end    = cfg_data[7:0];
          REG_TAG_SIGNAL:    code_signal = cfg_data[7:0];
          REG_TAG_NOISE:     code_noise  = cfg_data[7:0];
          REG_TAG_FCS_ERROR: code_fcs    = cfg_data[7:0];
          REG_DROP_ALL:      paused      = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frame_q.size() == 0) begin
          $error("frame beat %0h with nothing outstanding", out_data.payload_byte);
          fail_count++;
        end else begin
          want = frame_q.pop_front();
          check_field("payload_byte", want.payload_byte, out_data.payload_byte);
          check_field("payload_last", want.payload_last, out_data.payload_last);
          check_field("signal_level", want.signal_level, out_data.signal_level);
          check_field("noise_level", want.noise_level, out_data.noise_level);
          check_field("fcs_error", want.fcs_error, out_data.fcs_error);
        end
      end
      if (in_valid && !in_stall) begin
        if (strip_byte(in_data, beat)) frame_q.push_back(beat);
      end
    end
    pending = frame_q.size();
  end

endmodule

/* verif/sensor_capture_header_tlv_strip_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_capture_header_tlv_strip_unit_tb
// Feeds capture datagrams through the header stripper: a directed set of
// corner cases, then mostly well-formed random datagrams under several tag
// and link-type settings, with bursty input and a wandering output stall.
// ----------------------------------------------------------------------------

module sensor_capture_header_tlv_strip_unit_tb;
  import scts_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_BEATS    = 220;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  out_stall = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ENCAP_TYPE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_stall, out_valid, cfg_ready;
  out_item_t             out_data;
  int                    fail_count, pending;

  // register values as last programmed, used to shape datagrams
  logic [15:0] cur_encap = ENCAP_TYPE_RST;
  logic [7:0]  cur_pad   = TAG_PAD_RST;
  logic [7:0]  cur_end   = TAG_END_RST;
  logic [7:0]  cur_sig   = TAG_SIGNAL_RST;
  logic [7:0]  cur_noise = TAG_NOISE_RST;
  logic [7:0]  cur_fcs   = TAG_FCS_ERROR_RST;

  logic [7:0]  dgram_q[$];
  int          burst_left  = 0;
  int          beats_sent  = 0;
  int          quiet_cycles = 0;
  int          stall_mode  = 0;
  int          mode_left   = 0;
  int          tick        = 0;

  sensor_capture_header_tlv_strip_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  scts_frame_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver stall, switching between free flow, random, periodic and heavy
  always @(posedge clk) begin
    tick++;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 4);
      mode_left  = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 1);
      2: out_stall <= ($urandom_range(0, 7) == 0);
      3: out_stall <= ((tick % 11) < 4);
      default: out_stall <= ($urandom_range(0, 15) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL sensor_capture_header_tlv_strip_unit");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= in_item_t'{in_byte: b, last_byte: last};
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic send_span(input int first, input int upto);
    for (int i = first; i <= upto; i++) send_beat(dgram_q[i], i == dgram_q.size() - 1);
  endtask

  task automatic send_dgram();
    send_span(0, dgram_q.size() - 1);
  endtask

  // drains every outstanding frame beat, then lets the pipeline settle
  task automatic wait_idle();
    in_valid  <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] encap, input logic [7:0] pad, t_end, sig,
                              noise, fcs, input logic pause);
    logic [CFG_IDX_W-1:0]  idx [7];
    logic [CFG_DATA_W-1:0] val [7];
    idx = '{REG_ENCAP_TYPE, REG_TAG_PAD, REG_TAG_END, REG_TAG_SIGNAL, REG_TAG_NOISE,
            REG_TAG_FCS_ERROR, REG_DROP_ALL};
    val = '{encap, 16'(pad), 16'(t_end), 16'(sig), 16'(noise), 16'(fcs), 16'(pause)};
    cur_encap = encap;
    cur_pad   = pad;
    cur_end   = t_end;
    cur_sig   = sig;
    cur_noise = noise;
    cur_fcs   = fcs;
    for (int k = 0; k < 7; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic start_dgram(input logic [15:0] link);
    dgram_q.delete();
    dgram_q.push_back(8'($urandom));
    dgram_q.push_back(8'($urandom));
    dgram_q.push_back(link[7:0]);
    dgram_q.push_back(link[15:8]);
  endtask

  // header, a handful of tags, end tag, then a mostly short frame
  task automatic build_good();
    logic [7:0] code;
    int         len;
    start_dgram(cur_encap);
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 4))
        0: code = cur_pad;
        1: code = cur_sig;
        2: code = cur_noise;
        3: code = cur_fcs;
        default: code = 8'($urandom);
      endcase
      dgram_q.push_back(code);
      if (code != cur_pad && code != cur_end) begin
        len = ($urandom_range(0, 29) == 0) ? $urandom_range(7, 255) : $urandom_range(0, 6);
        dgram_q.push_back(len[7:0]);
        repeat (len) dgram_q.push_back(8'($urandom));
      end
    end
    dgram_q.push_back(cur_end);
    repeat (($urandom_range(0, 19) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12))
      dgram_q.push_back(8'($urandom));
  endtask

  task automatic random_dgram();
    int r, n;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      build_good();
    end else if (r < 82) begin
      build_good();
      n = $urandom_range(2, 3);
      dgram_q[n] = dgram_q[n] ^ (8'd1 << $urandom_range(0, 7));
    end else if (r < 90) begin
      build_good();
      n = $urandom_range(1, dgram_q.size() - 1);
      while (dgram_q.size() > n) void'(dgram_q.pop_back());
    end else begin
      dgram_q.delete();
      repeat ((r < 95) ? $urandom_range(1, 3) : $urandom_range(1, 24))
        dgram_q.push_back(8'($urandom));
    end
    send_dgram();
  endtask

  task automatic random_run(input int beats);
    int goal;
    goal = beats_sent + beats;
    while (beats_sent < goal) random_dgram();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values: levels at both extremes, FCS flag, pad, three-byte frame
    dgram_q = '{8'hFF, 8'h00, cur_encap[7:0], cur_encap[15:8],
                cur_sig, 8'h01, 8'hFF, cur_noise, 8'h02, 8'h00, 8'hAA,
                cur_fcs, 8'h00, cur_pad, cur_end, 8'h00, 8'hFF, 8'h5A};
    send_dgram();
    // zero-length signal tag grabs the next tag byte as its level
    dgram_q = '{8'h00, 8'hFF, cur_encap[7:0], cur_encap[15:8],
                cur_sig, 8'h00, cur_noise, 8'h01, 8'h07, cur_end, 8'h80};
    send_dgram();
    dgram_q = '{8'h01};
    send_dgram();
    dgram_q = '{8'h01, 8'h02, 8'h03};
    send_dgram();
    dgram_q = '{8'h00, 8'h00, cur_encap[7:0], cur_encap[15:8]};
    send_dgram();
    // wrong link type
    dgram_q = '{8'h00, 8'h00, cur_encap[7:0] ^ 8'h01, cur_encap[15:8], cur_end, 8'hEE};
    send_dgram();
    // end tag on the final byte
    dgram_q = '{8'h00, 8'h00, cur_encap[7:0], cur_encap[15:8], cur_end};
    send_dgram();
    // no end tag; ends inside skipped bytes; ends on an unknown tag byte
    dgram_q = '{8'h00, 8'h00, cur_encap[7:0], cur_encap[15:8], cur_sig, 8'h01, 8'h09, cur_pad};
    send_dgram();
    dgram_q = '{8'h00, 8'h00, cur_encap[7:0], cur_encap[15:8], 8'h80, 8'h05, 8'h01, 8'h02};
    send_dgram();
    dgram_q = '{8'h00, 8'h00, cur_encap[7:0], cur_encap[15:8], 8'hFF};
    send_dgram();
    wait_idle();

    // clashing codes: noise beats FCS, end beats signal
    program_regs(16'hFFFF, 8'hFF, 8'h20, 8'h20, 8'h30, 8'h30, 1'b0);
    dgram_q = '{8'h00, 8'h00, 8'hFF, 8'hFF, cur_pad, cur_noise, 8'h01, 8'h44, cur_end, 8'hC3};
    send_dgram();
    wait_idle();
    // signal beats noise; pad beats end
    program_regs(16'h8001, 8'h01, 8'h02, 8'h40, 8'h40, 8'h50, 1'b0);
    dgram_q = '{8'hFF, 8'hFF, 8'h01, 8'h80, cur_pad, cur_sig, 8'h01, 8'h99,
                cur_fcs, 8'h00, cur_end, 8'h00, 8'hFF};
    send_dgram();
    wait_idle();
    program_regs(16'h8001, 8'h01, 8'h01, 8'h40, 8'h41, 8'h50, 1'b0);
    dgram_q = '{8'hFF, 8'hFF, 8'h01, 8'h80, cur_end, 8'h33};
    send_dgram();
    wait_idle();

    // paused, then resumed part way through: the datagram stays dropped
    program_regs(ENCAP_TYPE_RST, TAG_PAD_RST, TAG_END_RST, TAG_SIGNAL_RST, TAG_NOISE_RST,
                 TAG_FCS_ERROR_RST, 1'b1);
    build_good();
    send_dgram();
    build_good();
    send_span(0, 4);
    wait_idle();
    program_regs(cur_encap, cur_pad, cur_end, cur_sig, cur_noise, cur_fcs, 1'b0);
    send_span(5, dgram_q.size() - 1);
    // paused in the middle of a frame
    start_dgram(cur_encap);
    dgram_q.push_back(cur_end);
    repeat (6) dgram_q.push_back(8'($urandom));
    send_span(0, 6);
    wait_idle();
    program_regs(cur_encap, cur_pad, cur_end, cur_sig, cur_noise, cur_fcs, 1'b1);
    send_span(7, dgram_q.size() - 1);
    wait_idle();

    program_regs(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 1'b0);
    random_run(PHASE_BEATS);
    wait_idle();
    program_regs(16'hFFFF, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 1'b0);
    random_run(PHASE_BEATS);
    wait_idle();
    // tiny code space, so clashes come up often
    program_regs(16'h0000, 8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                 8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                 8'($urandom_range(0, 7)), 1'b0);
    random_run(PHASE_BEATS);
    wait_idle();
    program_regs(16'h0000, 8'h00, 8'hFF, 8'hFE, 8'hFD, 8'hFC, 1'b0);
    random_run(PHASE_BEATS);
    wait_idle();
    program_regs(16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 1'b0);
    random_run(PHASE_BEATS);
    wait_idle();
    program_regs(16'($urandom), cur_pad, cur_end, cur_sig, cur_noise, cur_fcs, 1'b1);
    random_run(60);
    wait_idle();
    program_regs(16'($urandom), TAG_PAD_RST, TAG_END_RST, TAG_SIGNAL_RST, TAG_NOISE_RST,
                 TAG_FCS_ERROR_RST, 1'b0);
    random_run(PHASE_BEATS);

    wait_idle();
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS sensor_capture_header_tlv_strip_unit");
    end else begin
      $display("FAIL sensor_capture_header_tlv_strip_unit");
    end
    $finish;
  end

endmodule
